// ===== hw/rtl/key_event_debounce_long_press_unit_assert.svh =====
// Assertion macros used by the checker module of the key event unit.
`ifndef KEY_EVENT_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH
`define KEY_EVENT_DEBOUNCE_LONG_PRESS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KEV_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KEV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/kev_pkg.sv =====
package kev_pkg;

    localparam int KEY_COUNT   = 128;
    localparam int KEY_W       = $clog2(KEY_COUNT);
    localparam int EVT_W       = 8;
    localparam int CODE_W      = 7;
    localparam int TIME_W      = 32;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 4;
    localparam int PRESS_BIT   = 7;
    localparam int MATRIX_KEYS = 80;
    localparam int MATRIX_COLS = 10;

    // Division by ten through a reciprocal; exact for values below 1024.
    localparam int ROW_RECIP = 205;
    localparam int ROW_SHIFT = 11;
    localparam int PROD_W    = 15;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    typedef struct packed {
        logic [TIME_W-1:0] debounce_ms;
        logic [TIME_W-1:0] long_press_ms;
    } kev_cfg_t;

    // One entry of the per-key store.
    typedef struct packed {
        logic [TIME_W-1:0] last_time;
        logic [TIME_W-1:0] press_time;
        logic              held;
    } kev_entry_t;

    localparam int ENTRY_W = $bits(kev_entry_t);

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              is_pressed;
        logic              on_matrix;
        logic [ROW_W-1:0]  row_index;
        logic [COL_W-1:0]  col_index;
        logic              long_hold;
    } kev_result_t;

    // Row of a zero-based matrix position.
    function automatic logic [ROW_W-1:0] kev_row(input logic [CODE_W-1:0] pos);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(pos) * PROD_W'(ROW_RECIP);
        return prod[ROW_SHIFT +: ROW_W];
    endfunction

    // Column of a zero-based matrix position, given its row.
    function automatic logic [COL_W-1:0] kev_col(input logic [CODE_W-1:0] pos,
                                                 input logic [ROW_W-1:0]  row);
        logic [CODE_W-1:0] rem;
        rem = pos - CODE_W'(row) * CODE_W'(MATRIX_COLS);
        return rem[COL_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/kev_ram.sv =====
module kev_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port; a read returns the old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/kev_core.sv =====
module kev_core
    import kev_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  kev_cfg_t          cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [EVT_W-1:0]  event_byte,
    input  logic [TIME_W-1:0] now_ms,
    output logic              res_valid,
    input  logic              res_ready,
    output kev_result_t       res
);

    logic               s1_valid_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic               s1_press_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic               s1_fwd_reg;
    kev_entry_t         s1_fwd_data_reg;
    logic [KEY_COUNT-1:0] written_reg;

    logic               accept;
    logic [KEY_W-1:0]   in_idx;
    logic [KEY_W-1:0]   s1_idx;
    logic [ENTRY_W-1:0] rd_data;
    kev_entry_t         entry;
    kev_entry_t         entry_next;
    logic [TIME_W-1:0]  since_last;
    logic [TIME_W-1:0]  held_for;
    logic               drop_bounce;
    logic               keep;
    logic               s1_adv;
    logic               wr_en;
    logic [CODE_W-1:0]  pos;
    logic [ROW_W-1:0]   row;

    assign accept = in_valid && in_ready;
    assign in_idx = event_byte[KEY_W-1:0];
    assign s1_idx = s1_code_reg[KEY_W-1:0];

    kev_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_idx),
        .wr_data (entry_next),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (rd_data)
    );

    // Entry as seen by the event in the second stage. A write in the cycle of
    // its read is forwarded; an entry never written reads as zero.
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            entry = s1_fwd_data_reg;
        end
        else if (written_reg[s1_idx])
        begin
            entry = kev_entry_t'(rd_data);
        end
        else
        begin
            entry = '0;
        end
    end

    // Debounce and long-press decisions.
    assign since_last  = s1_now_reg - entry.last_time;
    assign held_for    = s1_now_reg - entry.press_time;
    assign drop_bounce = (cfg.debounce_ms != '0) && (since_last < cfg.debounce_ms);
    assign keep        = (s1_code_reg != '0) && !drop_bounce;

    always_comb
    begin
        entry_next.last_time  = s1_now_reg;
        entry_next.press_time = s1_press_reg ? s1_now_reg : entry.press_time;
        entry_next.held       = s1_press_reg;
    end

    // Matrix position of the key.
    assign pos = s1_code_reg - CODE_W'(1);
    assign row = kev_row(pos);

    always_comb
    begin
        res.key_code   = s1_code_reg;
        res.is_pressed = s1_press_reg;
        res.on_matrix  = (s1_code_reg <= CODE_W'(MATRIX_KEYS));
        res.row_index  = res.on_matrix ? row : '0;
        res.col_index  = res.on_matrix ? kev_col(pos, row) : '0;
        res.long_hold  = !s1_press_reg && entry.held && (cfg.long_press_ms != '0)
                         && (held_for >= cfg.long_press_ms);
    end

    // Handshake: a dropped event leaves at once, a kept one when taken.
    assign res_valid = s1_valid_reg && keep;
    assign s1_adv    = s1_valid_reg && (!keep || res_ready);
    assign wr_en     = s1_valid_reg && keep && res_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;

    // Second stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            written_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (wr_en)
            begin
                written_reg[s1_idx] <= 1'b1;
            end
        end
    end

    // Second stage payload, with the forwarding capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_code_reg     <= event_byte[CODE_W-1:0];
            s1_press_reg    <= event_byte[PRESS_BIT];
            s1_now_reg      <= now_ms;
            s1_fwd_reg      <= wr_en && (s1_idx == in_idx);
            s1_fwd_data_reg <= entry_next;
        end
    end

endmodule

// ===== hw/rtl/key_event_debounce_long_press_unit.sv =====
// Key event debounce with long-press detection.
// Each accepted event is registered in the second stage, its result in the output register.
// Throughput: one event per cycle while the output is not stalled; the per-key
// memory is read in the accept cycle and written back from the second stage, forwarded.
// Reset clears the valid and configuration registers and the per-key written flags,
// so every key entry reads as zero at once; no clearing pass is needed.
module key_event_debounce_long_press_unit
    import kev_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [EVT_W-1:0]     event_byte,
    input  logic [TIME_W-1:0]    now_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CODE_W-1:0]    key_code,
    output logic                 is_pressed,
    output logic                 on_matrix,
    output logic [ROW_W-1:0]     row_index,
    output logic [COL_W-1:0]     col_index,
    output logic                 long_hold
);

    kev_cfg_t    cfg_reg;
    logic        out_valid_reg;
    kev_result_t out_reg;
    logic        res_valid;
    logic        res_ready;
    kev_result_t res;

    // Configuration registers; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:   cfg_reg.debounce_ms   <= cfg_data;
                CFG_LONG_PRESS: cfg_reg.long_press_ms <= cfg_data;
                default:        cfg_reg               <= cfg_reg;
            endcase
        end
    end

    kev_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .event_byte (event_byte),
        .now_ms     (now_ms),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register holding one result beat.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_code   = out_reg.key_code;
    assign is_pressed = out_reg.is_pressed;
    assign on_matrix  = out_reg.on_matrix;
    assign row_index  = out_reg.row_index;
    assign col_index  = out_reg.col_index;
    assign long_hold  = out_reg.long_hold;

endmodule

// ===== hw/rtl/kev_checker.sv =====
`include "key_event_debounce_long_press_unit_assert.svh"

module kev_checker
    import kev_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [CODE_W-1:0]    key_code,
    input  logic                 is_pressed,
    input  logic                 on_matrix,
    input  logic [ROW_W-1:0]     row_index,
    input  logic [COL_W-1:0]     col_index,
    input  logic                 long_hold
);

    // A stalled result beat holds its key and direction.
    `KEV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(key_code) && $stable(is_pressed), "stalled result beat changed")

    // Keycode zero never produces a result, and matrix membership follows the code.
    `KEV_ASSERT_SAME(a_code_map, clk, rst_n, out_valid, (key_code != '0) && (on_matrix == (key_code <= CODE_W'(MATRIX_KEYS))), "bad keycode or matrix flag")

    // Off-matrix keys carry a zero position; on-matrix columns stay below ten.
    `KEV_ASSERT_SAME(a_position, clk, rst_n, out_valid, on_matrix ? (col_index < COL_W'(MATRIX_COLS)) : (row_index == '0 && col_index == '0), "bad matrix position")

    // A press never carries the long-press flag.
    `KEV_ASSERT_SAME(a_press_lp, clk, rst_n, out_valid && is_pressed, !long_hold, "long press flagged on a press")

endmodule

bind key_event_debounce_long_press_unit kev_checker u_kev_checker (.*);
